[rtl/core/rffa_pkg.sv]
// Shared types and constants for the ring first-fit slot allocator.
// Holds the request and response payload structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rffa_pkg;

   localparam int SIZE_W  = 3;
   localparam int INDEX_W = 3;

   localparam logic MODE_BLOCK  = 1'b0;
   localparam logic MODE_SINGLE = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [SIZE_W-1:0]  block_size;
      logic [INDEX_W-1:0] start_index;
   } req_type;

   typedef struct packed {
      logic               placed;
      logic [INDEX_W-1:0] placed_index;
      logic               ring_cleared;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/rffa_run_probe.sv]
// Run probe for the slot allocator: tests one candidate run of slots and
// builds its write mask. Depends on rffa_pkg for the size width.
`timescale 1ns / 1ps
`default_nettype none

module rffa_run_probe #(
   parameter int SLOTS     = 8,
   parameter int MAX_BLOCK = 4,
   parameter int IDX_W     = 3
) (
   input  wire logic [IDX_W-1:0]            pos,
   input  wire logic [rffa_pkg::SIZE_W-1:0] len,
   input  wire logic [SLOTS-1:0]            occ,
   output logic                             run_free,
   output logic [SLOTS-1:0]                 run_mask
);

   // Walk the run from pos, wrapping at the ring end; repeats fold into the mask.
   always_comb begin
      logic [IDX_W-1:0] idx;
      idx      = pos;
      run_mask = '0;
      for (int j = 0; j < MAX_BLOCK; j++) begin
         if (4'(j) < {1'b0, len}) begin
            run_mask[idx] = 1'b1;
         end
         idx = (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
      end
      run_free = ((run_mask & occ) == '0);
   end

endmodule

`default_nettype wire

[rtl/core/ring_first_fit_slot_allocator_core.sv]
// Ring first-fit slot allocator: top level with the scan sequencer.
// A request with size zero or above MAX_BLOCK gives its response in the
// cycle after acceptance; any other request tries start positions in ring
// order (1 to SLOTS of them, the run probe tests one position a cycle)
// and then presents the response.
// One request is in flight at a time; the next is taken the cycle after the
// response is accepted. Synchronous reset marks every slot free at once.
// Depends on rffa_pkg and rffa_run_probe.
`timescale 1ns / 1ps
`default_nettype none

module ring_first_fit_slot_allocator_core #(
   parameter int SLOTS     = 8,
   parameter int MAX_BLOCK = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rffa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rffa_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int RW    = (IDX_W > rffa_pkg::INDEX_W) ? IDX_W : rffa_pkg::INDEX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [SLOTS-1:0]              occ_ff, occ_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;
   logic [IDX_W-1:0]              count_ff, count_in;
   logic [rffa_pkg::SIZE_W-1:0]   len_ff, len_in;
   logic                          mode_ff, mode_in;
   rffa_pkg::rsp_type             rsp_ff, rsp_in;

   logic [IDX_W-1:0]              start_mod;
   logic                          size_ok;
   logic                          run_free;
   logic [SLOTS-1:0]              run_mask;

   rffa_run_probe #(
      .SLOTS     (SLOTS),
      .MAX_BLOCK (MAX_BLOCK),
      .IDX_W     (IDX_W)
   ) u_probe (
      .pos      (pos_ff),
      .len      (len_ff),
      .occ      (occ_ff),
      .run_free (run_free),
      .run_mask (run_mask)
   );

   // Reduce the start index into the ring; three subtract steps cover 7 mod 2.
   always_comb begin
      logic [RW:0] v;
      v = (RW + 1)'(req_data.start_index);
      for (int s = 0; s < 3; s++) begin
         if (v >= (RW + 1)'(SLOTS)) begin
            v = v - (RW + 1)'(SLOTS);
         end
      end
      start_mod = v[IDX_W-1:0];
   end

   assign size_ok = (req_data.block_size != '0) &&
                    ({1'b0, req_data.block_size} <= 4'(MAX_BLOCK));

   always_comb begin
      state_in = state_ff;
      occ_in   = occ_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      len_in   = len_ff;
      mode_in  = mode_ff;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pos_in   = start_mod;
               count_in = '0;
               mode_in  = req_data.mode;
               len_in   = (req_data.mode == rffa_pkg::MODE_SINGLE) ?
                          rffa_pkg::SIZE_W'(1) : req_data.block_size;
               rsp_in   = '0;
               state_in = size_ok ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (run_free) begin
               occ_in              = occ_ff | run_mask;
               rsp_in.placed       = 1'b1;
               rsp_in.placed_index = rffa_pkg::INDEX_W'(pos_ff);
               state_in            = ST_DONE;
            end else if (count_ff == IDX_W'(SLOTS - 1)) begin
               // No position fits: a block request wipes the ring.
               if (mode_ff == rffa_pkg::MODE_BLOCK) begin
                  occ_in              = '0;
                  rsp_in.ring_cleared = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               pos_in   = (pos_ff == IDX_W'(SLOTS - 1)) ? '0 : pos_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
      pos_ff   <= pos_in;
      count_ff <= count_in;
      len_ff   <= len_in;
      mode_ff  <= mode_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
